[src/ptt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the periodic task timer table.
// No dependencies; imported by ptt_ctrl, the top level and the testbench.
package ptt_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int PERIOD_W  = 24;
    localparam int ID_W      = 16;
    localparam int STEP_W    = 8;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_FIRED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;

    // One table entry as held in the RAM word
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] remaining;
        logic [ID_W-1:0]     ident;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Result request from the sequencer to the output register
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     task_id;
        logic                last;
    } t_emit;

endpackage

[src/ptt_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/ptt_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the task table: add, remove and tick walks over the RAM.
// Depends on ptt_pkg; drives the ports of one ptt_ram.
module ptt_ctrl
    import ptt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OP_W-1:0]     i_op,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic [ID_W-1:0]     i_remove_id,
    input  logic [STEP_W-1:0]   i_tick_step,
    input  logic                i_out_free,
    output t_emit               o_emit,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    input  t_entry              i_rd_data,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output t_entry              o_wr_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TICK  = 5'b00010,
        S_FIND  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // Entries sit at positions 0 .. count-1, oldest at 0, newest at count-1
    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_pos, n_pos;
    logic [ID_W-1:0]     r_next_id, n_next_id;
    logic [ID_W-1:0]     r_rid, n_rid;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [ID_W-1:0]     r_res_id, n_res_id;

    logic [CW-1:0] count_m1;
    logic [AW-1:0] last_pos;
    logic          fire;
    logic          hold;

    assign count_m1   = r_count - CW'(1);
    assign last_pos   = count_m1[AW-1:0];
    assign fire       = i_rd_data.remaining < {{(PERIOD_W-STEP_W){1'b0}}, i_tick_step};
    assign hold       = fire && (r_res_status == ST_FIRED) && !i_out_free;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_next_id    = r_next_id;
        n_rid        = r_rid;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        o_rd_en      = 1'b0;
        o_rd_addr    = '0;
        o_wr_en      = 1'b0;
        o_wr_addr    = '0;
        o_wr_data    = i_rd_data;
        o_emit       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_op)
                        OP_TICK: begin
                            n_res_status = ST_NONE;
                            n_res_id     = '0;
                            if (r_count == '0) begin
                                n_state = S_DONE;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = last_pos;
                                n_pos     = last_pos;
                                n_state   = S_TICK;
                            end
                        end
                        OP_ADD: begin
                            if (r_count == CW'(SLOTS)) begin
                                n_res_status = ST_FULL;
                                n_res_id     = '0;
                            end else begin
                                o_wr_en             = 1'b1;
                                o_wr_addr           = r_count[AW-1:0];
                                o_wr_data.period    = i_period;
                                o_wr_data.remaining = i_period;
                                o_wr_data.ident     = r_next_id;
                                n_count             = r_count + CW'(1);
                                n_next_id           = r_next_id + ID_W'(1);
                                n_res_status        = ST_ADDED;
                                n_res_id            = r_next_id;
                            end
                            n_state = S_DONE;
                        end
                        OP_REMOVE: begin
                            n_rid = i_remove_id;
                            if (r_count == '0) begin
                                n_res_status = ST_NOTFOUND;
                                n_res_id     = i_remove_id;
                                n_state      = S_DONE;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = last_pos;
                                n_pos     = last_pos;
                                n_state   = S_FIND;
                            end
                        end
                        default: begin
                            n_res_status = ST_NONE;
                            n_res_id     = '0;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end

            S_TICK: begin
                // Hold the entry while an earlier fired request cannot leave yet
                if (!hold) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_pos;
                    if (fire) begin
                        o_wr_data.remaining = i_rd_data.period;
                        if (r_res_status == ST_FIRED) begin
                            o_emit.valid   = 1'b1;
                            o_emit.status  = ST_FIRED;
                            o_emit.task_id = r_res_id;
                            o_emit.last    = 1'b0;
                        end
                        n_res_status = ST_FIRED;
                        n_res_id     = i_rd_data.ident;
                    end else begin
                        o_wr_data.remaining = i_rd_data.remaining
                                              - {{(PERIOD_W-STEP_W){1'b0}}, i_tick_step};
                    end
                    if (r_pos == '0) begin
                        n_state = S_DONE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = r_pos - AW'(1);
                        n_pos     = r_pos - AW'(1);
                    end
                end
            end

            S_FIND: begin
                if (i_rd_data.ident == r_rid) begin
                    if (CW'(r_pos) == count_m1) begin
                        n_count      = count_m1;
                        n_res_status = ST_REMOVED;
                        n_res_id     = r_rid;
                        n_state      = S_DONE;
                    end else begin
                        // Close the gap: move every newer entry down by one
                        o_rd_en   = 1'b1;
                        o_rd_addr = r_pos + AW'(1);
                        n_state   = S_SHIFT;
                    end
                end else if (r_pos == '0) begin
                    n_res_status = ST_NOTFOUND;
                    n_res_id     = r_rid;
                    n_state      = S_DONE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_pos - AW'(1);
                    n_pos     = r_pos - AW'(1);
                end
            end

            S_SHIFT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_pos;
                if ((CW+1)'(r_pos) + (CW+1)'(2) < {1'b0, r_count}) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_pos + AW'(2);
                    n_pos     = r_pos + AW'(1);
                end else begin
                    n_count      = count_m1;
                    n_res_status = ST_REMOVED;
                    n_res_id     = r_rid;
                    n_state      = S_DONE;
                end
            end

            S_DONE: begin
                if (i_out_free) begin
                    o_emit.valid   = 1'b1;
                    o_emit.status  = r_res_status;
                    o_emit.task_id = r_res_id;
                    o_emit.last    = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_next_id <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_next_id <= n_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_rid        <= n_rid;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
    end

endmodule

[src/periodic_task_timer_table_unit.sv]
`timescale 1ns / 1ps
// Top level of the periodic task timer table: config register, output register.
// Depends on ptt_pkg, ptt_ctrl and ptt_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request: tick, add
//   or remove. Output channel (o_out_valid / i_out_stall) returns one or
//   more results per request; o_last marks the final one. A request is taken
//   only while the sequencer is idle, one request at a time. The sequencer
//   returns to idle as the final result enters the output register.
//   Add, unknown op, or tick or remove on an empty table: the sequencer goes
//   straight to S_DONE, and the result enters the output register once free.
//   Remove: entries are searched one at a time from the newest down, then
//   each newer entry is moved down one place to close the gap, and the
//   result leaves from S_DONE.
//   Tick: one RAM entry per cycle through the read-modify-write loop,
//   newest entry first, pausing while a fired entry is held. The single RAM
//   port pair (one read, one write per cycle) sets this rate.
//   tick_step is written through i_cfg_we / i_cfg_wdata; the user must write it
//   only while idle, as the block itself does not enforce this. Reset (synchronous,
//   active low) empties the table, zeroes the id counter and sets tick_step to 1;
//   no clearing pass is needed. A stalled receiver holds the output register; the
//   walk pauses on the next fired entry until the register drains.
module periodic_task_timer_table_unit
    import ptt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OP_W-1:0]     i_op,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic [ID_W-1:0]     i_remove_id,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_task_id,
    output logic                o_last,
    input  logic                i_cfg_we,
    input  logic [STEP_W-1:0]   i_cfg_wdata
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [STEP_W-1:0]   r_tick_step;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [ID_W-1:0]     r_task_id;
    logic                r_last;
    logic                out_free;
    t_emit               emit;

    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    t_entry              rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_entry              wr_data;
    logic [ENTRY_W-1:0]  rd_word;

    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_data  = t_entry'(rd_word);

    ptt_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_period    (i_period),
        .i_remove_id (i_remove_id),
        .i_tick_step (r_tick_step),
        .i_out_free  (out_free),
        .o_emit      (emit),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    ptt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_step <= STEP_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tick_step <= i_cfg_wdata;
            end
            if (emit.valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load a new request only when the register is free
    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_status  <= emit.status;
            r_task_id <= emit.task_id;
            r_last    <= emit.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_task_id   = r_task_id;
    assign o_last      = r_last;

endmodule

[test/periodic_task_timer_table_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for periodic_task_timer_table_unit: directed table, random
// requests and a closing pass without idling, checked against a behavioural table copy
// or fixed expected results. Depends on ptt_pkg and the RTL of the block.
module periodic_task_timer_table_unit_test;
    import ptt_pkg::*;

    localparam int SLOTS = SLOTS_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
    localparam int RANDOM_PER_PHASE = 60;
    localparam int PHASES = 6;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     task_id;
        logic                last;
    } t_result;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [PERIOD_W-1:0] period;
        logic [ID_W-1:0]     rid;
        int                  rep;
        bit                  typed;
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     task_id;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_op = '0;
    logic [PERIOD_W-1:0] i_period = '0;
    logic [ID_W-1:0]     i_remove_id = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_task_id;
    logic                o_last;
    logic                i_cfg_we = 1'b0;
    logic [STEP_W-1:0]   i_cfg_wdata = '0;

    periodic_task_timer_table_unit #(.SLOTS(SLOTS)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_period    (i_period),
        .i_remove_id (i_remove_id),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_task_id   (o_task_id),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Behavioural copy of the task table
    bit                  tbl_valid [SLOTS];
    logic [PERIOD_W-1:0] tbl_period [SLOTS];
    logic [PERIOD_W-1:0] tbl_remaining [SLOTS];
    logic [ID_W-1:0]     tbl_ident [SLOTS];
    int                  tbl_rank [SLOTS];
    logic [ID_W-1:0]     next_id = '0;
    logic [STEP_W-1:0]   step_now = 8'd1;

    t_result awaited_results [$];
    t_result step_results [$];
    bit      idle_on = 1'b1;
    int      errors = 0;
    int      stall_left = 0;
    int      quiet_cycles = 0;

    task automatic advance_table(input logic [OP_W-1:0] op, input logic [PERIOD_W-1:0] per,
                                 input logic [ID_W-1:0] rid);
        int slot;
        int hit;
        logic [ID_W-1:0] fired [$];
        step_results.delete();
        case (op)
            OP_ADD: begin
                slot = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (!tbl_valid[i] && slot < 0) slot = i;
                if (slot < 0) begin
                    step_results.push_back('{ST_FULL, '0, 1'b1});
                end else begin
                    for (int i = 0; i < SLOTS; i++)
                        if (tbl_valid[i]) tbl_rank[i]++;
                    tbl_valid[slot]     = 1'b1;
                    tbl_period[slot]    = per;
                    tbl_remaining[slot] = per;
                    tbl_ident[slot]     = next_id;
                    tbl_rank[slot]      = 0;
                    step_results.push_back('{ST_ADDED, next_id, 1'b1});
                    next_id++;
                end
            end
            OP_REMOVE: begin
                hit = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_valid[i] && tbl_ident[i] == rid &&
                        (hit < 0 || tbl_rank[i] < tbl_rank[hit]))
                        hit = i;
                if (hit < 0) begin
                    step_results.push_back('{ST_NOTFOUND, rid, 1'b1});
                end else begin
                    tbl_valid[hit] = 1'b0;
                    for (int i = 0; i < SLOTS; i++)
                        if (tbl_valid[i] && tbl_rank[i] > tbl_rank[hit]) tbl_rank[i]--;
                    step_results.push_back('{ST_REMOVED, rid, 1'b1});
                end
            end
            OP_TICK: begin
                // visit newest first
                for (int r = 0; r < SLOTS; r++)
                    for (int i = 0; i < SLOTS; i++) begin
                        if (tbl_valid[i] && tbl_rank[i] == r) begin
                            if (tbl_remaining[i] >= PERIOD_W'(step_now)) begin
                                tbl_remaining[i] -= PERIOD_W'(step_now);
                            end else begin
                                tbl_remaining[i] = tbl_period[i];
                                fired.push_back(tbl_ident[i]);
                            end
                        end
                    end
                if (fired.size() == 0)
                    step_results.push_back('{ST_NONE, '0, 1'b1});
                foreach (fired[k])
                    step_results.push_back('{ST_FIRED, fired[k], k == fired.size() - 1});
            end
            default: step_results.push_back('{ST_NONE, '0, 1'b1});
        endcase
    endtask

    task automatic send_request(input logic [OP_W-1:0] op, input logic [PERIOD_W-1:0] per,
                                input logic [ID_W-1:0] rid, input bit typed,
                                input logic [STATUS_W-1:0] want_status,
                                input logic [ID_W-1:0] want_id);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_period    <= per;
        i_remove_id <= rid;
        do @(posedge i_clk); while (o_in_stall);
        advance_table(op, per, rid);
        if (typed) begin
            awaited_results.push_back('{want_status, want_id, 1'b1});
        end else begin
            foreach (step_results[k]) awaited_results.push_back(step_results[k]);
        end
    endtask

    // Drop the request line, let every awaited result drain, then let the block settle
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tick_step(input logic [STEP_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        step_now = value;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    function automatic t_row row(input logic [OP_W-1:0] op, input logic [PERIOD_W-1:0] per,
                                 input logic [ID_W-1:0] rid, input int rep, input bit typed,
                                 input logic [STATUS_W-1:0] status,
                                 input logic [ID_W-1:0] task_id);
        t_row r;
        r.op = op;
        r.period = per;
        r.rid = rid;
        r.rep = rep;
        r.typed = typed;
        r.status = status;
        r.task_id = task_id;
        return r;
    endfunction

    // Output side starts random stall bursts only while idle_on is set
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing awaited, status", o_status, 0);
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_task_id !== want.task_id)
                    report_mismatch("task_id", o_task_id, want.task_id);
                if (o_last !== want.last) report_mismatch("last", o_last, want.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_row rows [$];
        logic [STEP_W-1:0] phase_step [PHASES];
        logic [ID_W-1:0] ids [$];
        logic [OP_W-1:0] op_r;
        logic [PERIOD_W-1:0] per_r;
        logic [ID_W-1:0] rid_r;
        int choice;

        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;

        rows.push_back(row(OP_TICK,   24'd0,        16'd0,      1, 1, ST_NONE,     16'd0));
        rows.push_back(row(OP_UNUSED, 24'hFFFFFF,   16'hFFFF,   1, 1, ST_NONE,     16'd0));
        rows.push_back(row(OP_REMOVE, 24'd0,        16'd0,      1, 1, ST_NOTFOUND, 16'd0));
        rows.push_back(row(OP_REMOVE, 24'hFFFFFF,   16'hFFFF,   1, 1, ST_NOTFOUND, 16'hFFFF));
        rows.push_back(row(OP_ADD,    24'd0,        16'hFFFF,   1, 1, ST_ADDED,    16'd0));
        rows.push_back(row(OP_ADD,    24'hFFFFFF,   16'd0,      1, 1, ST_ADDED,    16'd1));
        rows.push_back(row(OP_ADD,    24'd1,        16'd0,      1, 1, ST_ADDED,    16'd2));
        rows.push_back(row(OP_TICK,   24'd0,        16'd0,      2, 0, ST_NONE,     16'd0));
        rows.push_back(row(OP_REMOVE, 24'd0,        16'd1,      1, 1, ST_REMOVED,  16'd1));
        rows.push_back(row(OP_REMOVE, 24'd0,        16'd1,      1, 1, ST_NOTFOUND, 16'd1));
        // fill the table with zero-period tasks, then overfill it
        rows.push_back(row(OP_ADD,    24'd0,        16'd0,     14, 0, ST_NONE,     16'd0));
        rows.push_back(row(OP_ADD,    24'd9,        16'd0,      1, 1, ST_FULL,     16'd0));
        rows.push_back(row(OP_TICK,   24'hFFFFFF,   16'hFFFF,   2, 0, ST_NONE,     16'd0));
        rows.push_back(row(OP_REMOVE, 24'd0,        16'd2,      1, 1, ST_REMOVED,  16'd2));
        // the full table consumed no id
        rows.push_back(row(OP_ADD,    24'd7,        16'd0,      1, 1, ST_ADDED,    16'd17));
        rows.push_back(row(OP_UNUSED, 24'd0,        16'd0,      1, 1, ST_NONE,     16'd0));
        rows.push_back(row(OP_TICK,   24'd0,        16'd0,      3, 0, ST_NONE,     16'd0));

        phase_step[0] = 8'd255;
        phase_step[1] = 8'd0;
        phase_step[2] = 8'd1;
        phase_step[3] = 8'($urandom_range(3, 254));
        phase_step[4] = 8'd2;
        phase_step[5] = 8'd128;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[n])
            repeat (rows[n].rep)
                send_request(rows[n].op, rows[n].period, rows[n].rid, rows[n].typed,
                             rows[n].status, rows[n].task_id);

        for (int ph = 0; ph < PHASES; ph++) begin
            write_tick_step(phase_step[ph]);
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                choice = $urandom_range(0, 99);
                case ($urandom_range(0, 9))
                    0:       per_r = PERIOD_W'($urandom());
                    1:       per_r = 24'hFFFFFF;
                    2:       per_r = 24'd0;
                    default: per_r = PERIOD_W'($urandom_range(0, int'(step_now) * 3 + 3));
                endcase
                rid_r = ID_W'($urandom());
                if (choice < 38) begin
                    op_r = OP_ADD;
                end else if (choice < 65) begin
                    op_r = OP_REMOVE;
                    // mostly hit a live task
                    ids.delete();
                    for (int i = 0; i < SLOTS; i++)
                        if (tbl_valid[i]) ids.push_back(tbl_ident[i]);
                    if (ids.size() > 0 && $urandom_range(0, 4) != 0)
                        rid_r = ids[$urandom_range(0, ids.size() - 1)];
                end else if (choice < 95) begin
                    op_r = OP_TICK;
                end else begin
                    op_r = OP_UNUSED;
                end
                send_request(op_r, per_r, rid_r, 0, ST_NONE, '0);
            end
        end

        // Last part without idling: empty the table, then a short fixed sequence
        idle_on = 1'b0;
        write_tick_step(8'd1);
        ids.delete();
        for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i]) ids.push_back(tbl_ident[i]);
        foreach (ids[k]) send_request(OP_REMOVE, 24'd0, ids[k], 0, ST_NONE, '0);
        send_request(OP_ADD, 24'd3, 16'd0, 0, ST_NONE, '0);
        send_request(OP_ADD, 24'd0, 16'd0, 0, ST_NONE, '0);
        send_request(OP_TICK, 24'd0, 16'd0, 0, ST_NONE, '0);
        send_request(OP_TICK, 24'd0, 16'd0, 0, ST_NONE, '0);
        send_request(OP_REMOVE, 24'd0, next_id - ID_W'(1), 0, ST_NONE, '0);
        send_request(OP_TICK, 24'd0, 16'd0, 0, ST_NONE, '0);

        wait_drained();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
src/ptt_pkg.sv
src/ptt_ram.sv
src/ptt_ctrl.sv
src/periodic_task_timer_table_unit.sv
test/periodic_task_timer_table_unit_test.sv
